// File: hw/rtl/vzc_pkg.sv
// ----------------------------------------------------------------------------
// vzc_pkg
// Shared types and codes for the varint / zigzag field codec.
// ----------------------------------------------------------------------------
package vzc_pkg;

	// opcode field
	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// fixed_format field
	localparam logic FMT_VARINT = 1'b0;
	localparam logic FMT_FIXED  = 1'b1;

	// width_code field
	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;
	localparam logic [1:0] WC_64 = 2'd3;

	// varint byte limits
	localparam logic [3:0] VARINT_MAX_32 = 4'd5;
	localparam logic [3:0] VARINT_MAX_64 = 4'd10;

	typedef struct packed {
		logic        opcode;
		logic        fixed_format;
		logic [1:0]  width_code;
		logic        is_signed;
		logic [63:0] value_in;
		logic [7:0]  byte_in;
	} in_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  byte_out;
		logic        value_valid;
		logic [63:0] value_out;
		logic        last;
	} out_t;

	// controller -> datapath
	typedef struct packed {
		logic load_enc;
		logic dec_step;
		logic emit_byte;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic slot_free;
		logic enc_last;
	} sts_t;

endpackage

// File: hw/rtl/vzc_ctrl.sv
// ----------------------------------------------------------------------------
// vzc_ctrl
// Sequencer: takes words in idle, emits a byte per cycle if output is free.
// ----------------------------------------------------------------------------
module vzc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          opcode,
	output logic          in_ready,
	input  vzc_pkg::sts_t sts,
	output vzc_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_ENC  = 1'b1;

	logic state_q;
	logic state_d;
	logic take;

	assign in_ready = (state_q == ST_IDLE) && sts.slot_free;
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd.load_enc  = take && (opcode == vzc_pkg::OP_ENCODE);
		cmd.dec_step  = take && (opcode == vzc_pkg::OP_DECODE);
		cmd.emit_byte = (state_q == ST_ENC) && sts.slot_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load_enc) begin
					state_d = ST_ENC;
				end
			end
			ST_ENC: begin
				if (cmd.emit_byte && sts.enc_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/vzc_datapath.sv
// ----------------------------------------------------------------------------
// vzc_datapath
// Encode shifter, decode accumulator, byte order register and output word.
// ----------------------------------------------------------------------------
module vzc_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_data,
	input  vzc_pkg::in_t  in_item,
	input  vzc_pkg::cmd_t cmd,
	output vzc_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_ready,
	output vzc_pkg::out_t out_item
);

	logic          le_q;
	logic [63:0]   enc_sh_q;
	logic [3:0]    enc_cnt_q;
	logic          enc_fixed_q;
	logic          enc_le_q;
	logic [63:0]   dec_acc_q;
	logic [3:0]    dec_cnt_q;
	logic          out_valid_q;
	vzc_pkg::out_t out_q;

	// encode load values
	logic [63:0] ld_sh;
	logic [3:0]  ld_cnt;
	logic [31:0] zz32;
	logic [63:0] zz64;

	// emit values
	logic        more;
	logic [7:0]  emit_byte;
	logic        emit_last;

	// decode step values
	logic [3:0]  nbytes;
	logic [3:0]  cnt_n;
	logic [6:0]  vsh;
	logic [63:0] acc_n;
	logic        dec_done;
	logic [63:0] dec_val;
	logic [31:0] uz32;
	logic [63:0] uz64;

	function automatic logic [63:0] sext(input logic [63:0] r, input logic [1:0] wc,
			input logic sgn);
		logic [63:0] v;
		v = r;
		unique case (wc)
			vzc_pkg::WC_8:  v = {{56{sgn & r[7]}},  r[7:0]};
			vzc_pkg::WC_16: v = {{48{sgn & r[15]}}, r[15:0]};
			vzc_pkg::WC_32: v = {{32{sgn & r[31]}}, r[31:0]};
			vzc_pkg::WC_64: v = r;
			default:        v = r;
		endcase
		return v;
	endfunction

	// ---- encode load ----
	always_comb begin
		zz32   = {in_item.value_in[30:0], 1'b0} ^ {32{in_item.value_in[31]}};
		zz64   = {in_item.value_in[62:0], 1'b0} ^ {64{in_item.value_in[63]}};
		ld_cnt = 4'd1 << in_item.width_code;
		ld_sh  = in_item.value_in;
		if (in_item.fixed_format == vzc_pkg::FMT_FIXED) begin
			if (!le_q) begin
				unique case (in_item.width_code)
					vzc_pkg::WC_8:  ld_sh = {in_item.value_in[7:0],  56'b0};
					vzc_pkg::WC_16: ld_sh = {in_item.value_in[15:0], 48'b0};
					vzc_pkg::WC_32: ld_sh = {in_item.value_in[31:0], 32'b0};
					vzc_pkg::WC_64: ld_sh = in_item.value_in;
					default:        ld_sh = in_item.value_in;
				endcase
			end
		end else if (in_item.width_code == vzc_pkg::WC_64) begin
			ld_sh = in_item.is_signed ? zz64 : in_item.value_in;
		end else begin
			ld_sh = {32'b0, in_item.is_signed ? zz32 : in_item.value_in[31:0]};
		end
	end

	// ---- encode emit ----
	always_comb begin
		more = |enc_sh_q[63:7];
		if (enc_fixed_q) begin
			emit_byte = enc_le_q ? enc_sh_q[7:0] : enc_sh_q[63:56];
			emit_last = (enc_cnt_q == 4'd1);
		end else begin
			emit_byte = {more, enc_sh_q[6:0]};
			emit_last = !more;
		end
	end

	// ---- decode step ----
	always_comb begin
		nbytes   = 4'd1 << in_item.width_code;
		cnt_n    = dec_cnt_q + 4'd1;
		vsh      = {3'b0, dec_cnt_q} * 7'd7;
		acc_n    = dec_acc_q;
		dec_done = 1'b0;
		dec_val  = '0;
		uz32     = '0;
		uz64     = '0;
		if (in_item.fixed_format == vzc_pkg::FMT_FIXED) begin
			if (le_q) begin
				acc_n = dec_acc_q | ({56'b0, in_item.byte_in} << {dec_cnt_q, 3'b0});
			end else begin
				acc_n = {dec_acc_q[55:0], in_item.byte_in};
			end
			dec_done = (cnt_n >= nbytes);
			dec_val  = sext(acc_n, in_item.width_code, in_item.is_signed);
		end else begin
			acc_n    = dec_acc_q | ({57'b0, in_item.byte_in[6:0]} << vsh);
			dec_done = !in_item.byte_in[7] ||
				(cnt_n >= ((in_item.width_code == vzc_pkg::WC_64) ?
					vzc_pkg::VARINT_MAX_64 : vzc_pkg::VARINT_MAX_32));
			uz32 = {1'b0, acc_n[31:1]} ^ {32{acc_n[0]}};
			uz64 = {1'b0, acc_n[63:1]} ^ {64{acc_n[0]}};
			if (in_item.width_code == vzc_pkg::WC_64) begin
				dec_val = in_item.is_signed ? uz64 : acc_n;
			end else if (in_item.is_signed) begin
				dec_val = {{32{uz32[31]}}, uz32};
			end else begin
				dec_val = {32'b0, acc_n[31:0]};
			end
		end
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q        <= 1'b0;
			dec_acc_q   <= '0;
			dec_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				le_q <= cfg_data;
			end
			if (cmd.dec_step) begin
				dec_acc_q <= dec_done ? 64'd0 : acc_n;
				dec_cnt_q <= dec_done ? 4'd0 : cnt_n;
			end
			if (cmd.emit_byte || (cmd.dec_step && dec_done)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (cmd.load_enc) begin
			enc_sh_q    <= ld_sh;
			enc_cnt_q   <= ld_cnt;
			enc_fixed_q <= in_item.fixed_format;
			enc_le_q    <= le_q;
		end else if (cmd.emit_byte) begin
			enc_cnt_q <= enc_cnt_q - 4'd1;
			if (enc_fixed_q) begin
				enc_sh_q <= enc_le_q ? {8'b0, enc_sh_q[63:8]} : {enc_sh_q[55:0], 8'b0};
			end else begin
				enc_sh_q <= {7'b0, enc_sh_q[63:7]};
			end
		end
		if (cmd.emit_byte) begin
			out_q.byte_valid  <= 1'b1;
			out_q.byte_out    <= emit_byte;
			out_q.value_valid <= 1'b0;
			out_q.value_out   <= '0;
			out_q.last        <= emit_last;
		end else if (cmd.dec_step && dec_done) begin
			out_q.byte_valid  <= 1'b0;
			out_q.byte_out    <= '0;
			out_q.value_valid <= 1'b1;
			out_q.value_out   <= dec_val;
			out_q.last        <= 1'b0;
		end
	end

	assign sts.slot_free = !out_valid_q || out_ready;
	assign sts.enc_last  = emit_last;
	assign out_valid     = out_valid_q;
	assign out_item      = out_q;

endmodule

// File: hw/rtl/varint_zigzag_field_codec_top.sv
// Decode: a completed value appears in the output word the next cycle after its last byte.
// Encode: the word is loaded, then one byte leaves per cycle while the output slot is free,
//   1 to 10 bytes from the byte shifter; an encode item holds the block until the last one.
// Throughput: one decode byte per cycle while the one output register is free; encode too.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, decode accumulator and
//   byte count zero, byte order big endian.
// ----------------------------------------------------------------------------
// varint_zigzag_field_codec_top
// Protobuf-style field codec: varint/zigzag and fixed-width encode and decode.
// ----------------------------------------------------------------------------
module varint_zigzag_field_codec_top (
	input  logic          clk,
	input  logic          arst_n,
	// configuration: little_endian register
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data,
	// input words
	input  logic          in_valid,
	output logic          in_ready,
	input  vzc_pkg::in_t  in_item,
	// result words
	output logic          out_valid,
	input  logic          out_ready,
	output vzc_pkg::out_t out_item
);

	vzc_pkg::cmd_t cmd;
	vzc_pkg::sts_t sts;

	// The user must write the register only while idle; not enforced here, so take it at once.
	assign cfg_ready = 1'b1;

	// Sequencer: in idle it takes a word whenever the output register is free
	// (or being drained). An encode word moves it to the emit state, where it
	// pushes one byte per free output slot and returns to idle on the last one.
	vzc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (in_item.opcode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: the encode shifter walks the value 7 bits (varint) or 8 bits
	// (fixed) per byte; the decode accumulator folds in one byte per word and
	// drops a finished value into the output register.
	vzc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: hw/rtl/vzc_checker.sv
// ----------------------------------------------------------------------------
// vzc_checker
// Port-level checks for the field codec, bound to the top level.
// ----------------------------------------------------------------------------
module vzc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input vzc_pkg::in_t  in_item,
	input logic          out_valid,
	input logic          out_ready,
	input vzc_pkg::out_t out_item
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result word changed while stalled");

	// a result carries a byte or a value, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.byte_valid != out_item.value_valid))
		else $error("result word kind is ambiguous");

	// decoded values carry no byte and no last flag
	a_value_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.value_valid |->
			!out_item.last && (out_item.byte_out == 8'd0))
		else $error("decoded value word has byte fields set");

	// an accepted encode word blocks input until its bytes are out
	a_enc_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_item.opcode == vzc_pkg::OP_ENCODE) |=> !in_ready)
		else $error("input taken right after an encode word");

	// mid-field bytes mean the encoder is still busy
	a_mid_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.byte_valid && !out_item.last |-> !in_ready)
		else $error("input taken in the middle of an encoded field");

endmodule

bind varint_zigzag_field_codec_top vzc_checker u_vzc_checker (.*);

// File: tb/varint_zigzag_field_codec_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_zigzag_field_codec_top_test
// Self-checking bench for the varint / zigzag field codec. Directed corner
// words come first, then three random phases with different byte orders and
// flow-control patterns. A scoreboard mirrors the codec and compares every
// result word, field by field.
// ----------------------------------------------------------------------------
module varint_zigzag_field_codec_top_test;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned STALL_LEN   = 200;
	localparam int unsigned SETTLE_CYC  = 24;
	localparam int unsigned PHASE_WORDS = 36;

	// Mirror of the codec: keeps its own byte order and decode state, and
	// turns every accepted input word into the result words it must cause.
	class field_codec_scoreboard;
		vzc_pkg::out_t expected_q[$];
		bit            order_le;
		logic [63:0]   dec_acc;
		int unsigned   dec_count;
		int unsigned   failures, reported;
		int unsigned   encodes, decodes, bytes_seen, values_seen;

		function new();
			order_le  = 1'b0;
			dec_acc   = '0;
			dec_count = 0;
			failures  = 0;
			reported  = 0;
			encodes   = 0;
			decodes   = 0;
			bytes_seen  = 0;
			values_seen = 0;
		endfunction

		function void set_order(bit le);
			order_le = le;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function logic [63:0] low_mask(int unsigned bits);
			return (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
		endfunction

		function logic [63:0] sext(logic [63:0] v, int unsigned bits);
			logic [63:0] m;
			m = low_mask(bits);
			v = v & m;
			if (bits < 64 && v[bits-1])
				v = v | ~m;
			return v;
		endfunction

		function void queue_byte(logic [7:0] b, bit fin);
			vzc_pkg::out_t o;
			o = '0;
			o.byte_valid = 1'b1;
			o.byte_out   = b;
			o.last       = fin;
			expected_q = {expected_q, o};
		endfunction

		function void queue_value(logic [63:0] v);
			vzc_pkg::out_t o;
			o = '0;
			o.value_valid = 1'b1;
			o.value_out   = v;
			expected_q = {expected_q, o};
		endfunction

		function void note_word(vzc_pkg::in_t w);
			int unsigned nbytes, bits, maxb, idx, sh, i;
			logic [63:0] v, m, r, b;
			b = {56'd0, w.byte_in};
			if (w.opcode == vzc_pkg::OP_ENCODE) begin
				encodes++;
				if (w.fixed_format == vzc_pkg::FMT_FIXED) begin
					nbytes = 1 << w.width_code;
					for (i = 0; i < nbytes; i++) begin
						idx = order_le ? i : (nbytes - 1 - i);
						v = w.value_in >> (8 * idx);
						queue_byte(v[7:0], i == nbytes - 1);
					end
				end else begin
					bits = (w.width_code == vzc_pkg::WC_64) ? 64 : 32;
					m = low_mask(bits);
					v = w.value_in & m;
					// zigzag: shift left, flip everything by the sign bit
					if (w.is_signed)
						v = ((v << 1) ^ {64{v[bits-1]}}) & m;
					while (v >= 64'h80) begin
						queue_byte((v[7:0] & 8'h7f) | 8'h80, 1'b0);
						v = v >> 7;
					end
					queue_byte(v[7:0], 1'b1);
				end
				return;
			end
			decodes++;
			if (w.fixed_format == vzc_pkg::FMT_FIXED) begin
				nbytes = 1 << w.width_code;
				bits = 8 * nbytes;
				if (order_le) begin
					sh = 8 * dec_count;
					if (sh < 64)
						dec_acc = dec_acc | (b << sh);
				end else begin
					dec_acc = (dec_acc << 8) | b;
				end
				dec_count++;
				if (dec_count >= nbytes) begin
					r = dec_acc & low_mask(bits);
					if (w.is_signed)
						r = sext(r, bits);
					queue_value(r);
					dec_acc = '0;
					dec_count = 0;
				end
			end else begin
				bits = (w.width_code == vzc_pkg::WC_64) ? 64 : 32;
				maxb = (w.width_code == vzc_pkg::WC_64) ? int'(vzc_pkg::VARINT_MAX_64) :
					int'(vzc_pkg::VARINT_MAX_32);
				sh = 7 * dec_count;
				if (sh < 64)
					dec_acc = dec_acc | ((b & 64'h7f) << sh);
				dec_count++;
				if (b < 64'h80 || dec_count >= maxb) begin
					m = low_mask(bits);
					r = dec_acc & m;
					if (w.is_signed) begin
						r = ((r >> 1) ^ {64{r[0]}}) & m;
						r = sext(r, bits);
					end
					queue_value(r);
					dec_acc = '0;
					dec_count = 0;
				end
			end
			dec_count = dec_count & 4'hf;
		endfunction

		function void report_failure(string what, vzc_pkg::out_t exp_w, vzc_pkg::out_t got);
			failures++;
			if (reported < 10) begin
				reported++;
				$display("%0t %s: expected bv=%0d byte=%02h vv=%0d value=%016h last=%0d",
					$realtime, what, exp_w.byte_valid, exp_w.byte_out, exp_w.value_valid,
					exp_w.value_out, exp_w.last);
				$display("%0t %s:      got bv=%0d byte=%02h vv=%0d value=%016h last=%0d",
					$realtime, what, got.byte_valid, got.byte_out, got.value_valid,
					got.value_out, got.last);
			end
		endfunction

		function void check_word(vzc_pkg::out_t got);
			vzc_pkg::out_t exp_w;
			if (got.byte_valid === 1'b1)
				bytes_seen++;
			if (got.value_valid === 1'b1)
				values_seen++;
			if (expected_q.size() == 0) begin
				report_failure("unexpected result word", '0, got);
				return;
			end
			exp_w = expected_q.pop_front();
			if (got.byte_valid !== exp_w.byte_valid || got.byte_out !== exp_w.byte_out ||
					got.value_valid !== exp_w.value_valid ||
					got.value_out !== exp_w.value_out || got.last !== exp_w.last)
				report_failure("result mismatch", exp_w, got);
		endfunction
	endclass

	// Every input starts at a known value.
	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          cfg_valid = 1'b0;
	logic          cfg_data  = 1'b0;
	logic          in_valid  = 1'b0;
	vzc_pkg::in_t  in_item   = '0;
	logic          out_ready = 1'b0;
	logic          cfg_ready, in_ready, out_valid;
	vzc_pkg::out_t out_item;

	field_codec_scoreboard sb = new();

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned sent_words    = 0;
	int unsigned cycle_count   = 0;
	bit          stall_request = 1'b0;

	varint_zigzag_field_codec_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog: end the run if the handshakes stop making progress.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("varint_zigzag_field_codec_top_test NOT OK");
		$finish;
	end

	// Result side: check every accepted word at the rising edge, then pick the
	// next ready level at the falling edge. A requested hold-off is counted here.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready)
				sb.check_word(out_item);
			@(negedge clk);
			if (stall_request && stall_left == 0) begin
				stall_left = STALL_LEN;
				stall_request = 1'b0;
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	function automatic vzc_pkg::in_t make_word(logic op, logic fmt, logic [1:0] wc,
			logic sgn, logic [63:0] val, logic [7:0] b);
		vzc_pkg::in_t w;
		w.opcode       = op;
		w.fixed_format = fmt;
		w.width_code   = wc;
		w.is_signed    = sgn;
		w.value_in     = val;
		w.byte_in      = b;
		return w;
	endfunction

	// Offer one word: idle first at random, then hold valid and payload until
	// the codec takes it. Valid stays high on return so words can go back to back.
	task automatic send_word(vzc_pkg::in_t w);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item  = w;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_word(w);
		sent_words++;
	endtask

	// Drop valid, wait for every expected word, then give the codec time to
	// finish anything that produces no result.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Write the byte-order register while the codec is idle.
	task automatic write_order(bit le);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = le;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.set_order(le);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One random burst: an encode, a well-formed varint or fixed field to
	// decode, or a few stray decode words with mixed formats.
	task automatic random_burst();
		int unsigned pick, nb, k, i;
		logic [1:0]  wc;
		logic        sgn;
		logic [7:0]  b;
		logic [63:0] v;
		pick = $urandom_range(0, 99);
		wc   = 2'($urandom_range(0, 3));
		sgn  = 1'($urandom_range(0, 1));
		if (pick < 40) begin
			v = {$urandom, $urandom};
			case ($urandom_range(0, 3))
				0: begin
					v = v >> $urandom_range(0, 63);
				end
				1: begin
					v = ~(v >> $urandom_range(0, 63));
				end
				default: begin
				end
			endcase
			send_word(make_word(vzc_pkg::OP_ENCODE, 1'($urandom_range(0, 1)), wc, sgn, v,
				8'($urandom_range(0, 255))));
		end else if (pick < 65) begin
			nb = (wc == vzc_pkg::WC_64) ? int'(vzc_pkg::VARINT_MAX_64) :
				int'(vzc_pkg::VARINT_MAX_32);
			k  = $urandom_range(1, nb);
			for (i = 0; i < k; i++) begin
				b = 8'($urandom_range(0, 255));
				// continuation on all but the last; a full-length field ends by count
				if (i < k - 1)
					b[7] = 1'b1;
				else if (k < nb)
					b[7] = 1'b0;
				send_word(make_word(vzc_pkg::OP_DECODE, vzc_pkg::FMT_VARINT, wc, sgn,
					{$urandom, $urandom}, b));
			end
		end else if (pick < 85) begin
			nb = 1 << wc;
			for (i = 0; i < nb; i++)
				send_word(make_word(vzc_pkg::OP_DECODE, vzc_pkg::FMT_FIXED, wc, sgn,
					{$urandom, $urandom}, 8'($urandom_range(0, 255))));
		end else begin
			k = $urandom_range(1, 3);
			for (i = 0; i < k; i++)
				send_word(make_word(vzc_pkg::OP_DECODE, 1'($urandom_range(0, 1)),
					2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					{$urandom, $urandom}, 8'($urandom_range(0, 255))));
		end
	endtask

	initial begin
		int unsigned i, goal;

		// Hold reset, then release it on a falling edge.
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 34;
		recv_idle_pct = 69;

		// Directed words, big-endian order from reset.
		// Varint encodes: zero, full 32-bit with junk above the width, all ones
		// at 64 bits, the most negative values under zigzag, and -1.
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_32, 1'b0,
			64'd0, 8'h00));
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_32, 1'b0,
			64'hdead_beef_ffff_ffff, 8'hff));
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_64, 1'b0,
			'1, 8'h00));
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_32, 1'b1,
			64'h0000_0000_8000_0000, 8'h00));
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_64, 1'b1,
			64'h8000_0000_0000_0000, 8'h00));
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_64, 1'b1,
			'1, 8'h00));
		// Narrow width codes fall back to 32-bit varints.
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_8, 1'b0,
			64'd300, 8'h00));
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_16, 1'b1,
			64'hffff_ffff_ffff_fffe, 8'h00));
		// Fixed encodes at every width.
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_FIXED, vzc_pkg::WC_8, 1'b0,
			64'h0123_4567_89ab_cdef, 8'h00));
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_FIXED, vzc_pkg::WC_16, 1'b0,
			64'h0123_4567_89ab_cdef, 8'h00));
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_FIXED, vzc_pkg::WC_32, 1'b1,
			64'h0123_4567_89ab_cdef, 8'h00));
		send_word(make_word(vzc_pkg::OP_ENCODE, vzc_pkg::FMT_FIXED, vzc_pkg::WC_64, 1'b0,
			64'h0123_4567_89ab_cdef, 8'h00));
		// Signed 32-bit varint decode of five 0xff bytes: the fifth ends the
		// field by count and its bits past the width drop.
		for (i = 0; i < 5; i++)
			send_word(make_word(vzc_pkg::OP_DECODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_32,
				1'b1, '0, 8'hff));
		// Signed fixed 16-bit decode: sign extension from bit 15.
		send_word(make_word(vzc_pkg::OP_DECODE, vzc_pkg::FMT_FIXED, vzc_pkg::WC_16, 1'b1,
			'0, 8'h80));
		send_word(make_word(vzc_pkg::OP_DECODE, vzc_pkg::FMT_FIXED, vzc_pkg::WC_16, 1'b1,
			'0, 8'h01));
		// Format change mid-field: two varint bytes, then a fixed 8-bit byte
		// whose limit is already passed, so it completes at once.
		send_word(make_word(vzc_pkg::OP_DECODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_64, 1'b0,
			'0, 8'h81));
		send_word(make_word(vzc_pkg::OP_DECODE, vzc_pkg::FMT_VARINT, vzc_pkg::WC_64, 1'b0,
			'0, 8'h82));
		send_word(make_word(vzc_pkg::OP_DECODE, vzc_pkg::FMT_FIXED, vzc_pkg::WC_8, 1'b0,
			'0, 8'h5a));

		// Random phase one: little endian, sender idles less than receiver.
		write_order(1'b1);
		goal = sent_words + PHASE_WORDS;
		while (sent_words < goal)
			random_burst();

		// Random phase two: big endian, idling roles swapped.
		write_order(1'b0);
		send_idle_pct = 69;
		recv_idle_pct = 34;
		goal = sent_words + PHASE_WORDS;
		while (sent_words < goal)
			random_burst();

		// Random phase three: little endian, no idling, and one long receiver
		// hold-off so the codec backs up into its input.
		write_order(1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 1'b1;
		goal = sent_words + PHASE_WORDS;
		while (sent_words < goal)
			random_burst();

		settle();

		$display("Covered %0d encode and %0d decode words in both byte orders,",
			sb.encodes, sb.decodes);
		$display("checking %0d encoded bytes and %0d decoded values; %0d failures.",
			sb.bytes_seen, sb.values_seen, sb.failures);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("varint_zigzag_field_codec_top_test OK");
		end else begin
			$display("varint_zigzag_field_codec_top_test NOT OK");
		end
		$finish;
	end

endmodule
